@@ design/uoad_pkg.sv @@
// Package for the ultrasonic obstacle-avoid drive core.
// Holds the command and distance types, direction codes, band thresholds and duties.
// No dependencies.
package uoad_pkg;

  localparam logic [2:0] DIR_STOP  = 3'd0;
  localparam logic [2:0] DIR_FWD   = 3'd1;
  localparam logic [2:0] DIR_BACK  = 3'd2;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_RIGHT = 3'd4;

  localparam logic [1:0] SENSOR_NONE = 2'd3;

  // ticks / 58 as (ticks * 18079) >> 20, exact below the saturation point
  localparam logic [14:0] CM_DIV_MUL   = 15'd18079;
  localparam int          CM_SHIFT     = 20;
  localparam logic [31:0] CM_SAT_TICKS = 32'd14848;
  localparam logic [7:0]  CM_SAT       = 8'd255;

  localparam logic [7:0] BAND_FAR   = 8'd40;
  localparam logic [7:0] BAND_MID   = 8'd33;
  localparam logic [7:0] BAND_NEAR  = 8'd25;
  localparam logic [7:0] BAND_CLOSE = 8'd18;
  localparam logic [7:0] BAND_STOP  = 8'd10;
  localparam logic [7:0] SIDE_WARN  = 8'd20;
  localparam logic [7:0] SIDE_CRIT  = 8'd10;

  localparam logic [9:0] DUTY_380  = 10'd380;
  localparam logic [9:0] DUTY_360  = 10'd360;
  localparam logic [9:0] DUTY_340  = 10'd340;
  localparam logic [9:0] DUTY_320  = 10'd320;
  localparam logic [9:0] DUTY_300  = 10'd300;
  localparam logic [9:0] DUTY_ZERO = 10'd0;
  localparam logic [9:0] DUTY_800  = 10'd800;
  localparam logic [9:0] DUTY_700  = 10'd700;
  localparam logic [9:0] DUTY_600  = 10'd600;
  localparam logic [9:0] DUTY_450  = 10'd450;

  typedef struct packed {
    logic [2:0] direction;
    logic [9:0] duty_a;
    logic [9:0] duty_b;
  } uoad_cmd_t;

  typedef struct packed {
    logic [7:0] front;
    logic [7:0] side_a;
    logic [7:0] side_b;
  } uoad_ranges_t;

endpackage

@@ design/uoad_if.sv @@
// Valid/ready channel interfaces for the obstacle-avoid drive core.
// Echo capture channel in, drive command channel out. No dependencies.
interface uoad_echo_if;
  logic        valid;
  logic        ready;
  logic [1:0]  sensor;
  logic [15:0] stamp;

  modport source (output valid, output sensor, output stamp, input ready);
  modport sink (input valid, input sensor, input stamp, output ready);
endinterface

interface uoad_drive_if;
  logic       valid;
  logic       ready;
  logic [2:0] direction;
  logic [9:0] duty_a;
  logic [9:0] duty_b;
  logic [7:0] front_cm;
  logic [7:0] side_a_cm;
  logic [7:0] side_b_cm;

  modport source (output valid, output direction, output duty_a, output duty_b,
                  output front_cm, output side_a_cm, output side_b_cm, input ready);
  modport sink (input valid, input direction, input duty_a, input duty_b,
                input front_cm, input side_a_cm, input side_b_cm, output ready);
endinterface

@@ design/uoad_capture.sv @@
// Echo pair capture for three sensors: edge pairing, wrap length, centimetre conversion.
// Depends on uoad_pkg.
module uoad_capture #(
  parameter int TIMER_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic [1:0]             sensor,
  input  logic [15:0]            stamp,
  output uoad_pkg::uoad_ranges_t ranges_next
);
  import uoad_pkg::*;

  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  logic [2:0]            pending;
  logic [2:0]            pending_next;
  logic [TIMER_BITS-1:0] first_stamp [3];
  logic [TIMER_BITS-1:0] first_stamp_next [3];
  logic [TIMER_BITS-1:0] ticks [3];
  logic [TIMER_BITS-1:0] ticks_next [3];
  logic [7:0]            range [3];
  logic [7:0]            range_next [3];

  logic [31:0]           stamp_ext;
  logic [31:0]           ticks_ext;
  logic [TIMER_BITS-1:0] t;
  logic [TIMER_BITS-1:0] first_sel;
  logic [TIMER_BITS-1:0] ticks_sel;
  logic [TIMER_BITS-1:0] ticks_new;
  logic [28:0]           prod;
  logic [7:0]            cm_new;

  always_comb begin
    stamp_ext = {16'd0, stamp};
    t         = stamp_ext[TIMER_BITS-1:0];
    first_sel = '0;
    ticks_sel = '0;
    for (int i = 0; i < 3; i++) begin
      if (sensor == 2'(i)) begin
        first_sel = first_stamp[i];
        ticks_sel = ticks[i];
      end
    end
    priority if (t > first_sel) begin
      ticks_new = t - first_sel;
    end else if (first_sel > t) begin
      ticks_new = (TMAX - first_sel) + t;
    end else begin
      ticks_new = ticks_sel;
    end
    ticks_ext = 32'(ticks_new);
    prod      = 29'(ticks_ext[13:0]) * 29'(CM_DIV_MUL);
    if (ticks_ext >= CM_SAT_TICKS) begin
      cm_new = CM_SAT;
    end else begin
      cm_new = prod[CM_SHIFT+7:CM_SHIFT];
    end

    pending_next = pending;
    for (int i = 0; i < 3; i++) begin
      first_stamp_next[i] = first_stamp[i];
      ticks_next[i]       = ticks[i];
      range_next[i]       = range[i];
      if (fire && sensor == 2'(i)) begin
        if (!pending[i]) begin
          first_stamp_next[i] = t;
          pending_next[i]     = 1'b1;
        end else begin
          ticks_next[i]   = ticks_new;
          range_next[i]   = cm_new;
          pending_next[i] = 1'b0;
        end
      end
    end
  end

  assign ranges_next.front  = range_next[0];
  assign ranges_next.side_a = range_next[1];
  assign ranges_next.side_b = range_next[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      for (int i = 0; i < 3; i++) begin
        first_stamp[i] <= '0;
        ticks[i]       <= '0;
        range[i]       <= '0;
      end
    end else if (fire) begin
      pending <= pending_next;
      for (int i = 0; i < 3; i++) begin
        first_stamp[i] <= first_stamp_next[i];
        ticks[i]       <= ticks_next[i];
        range[i]       <= range_next[i];
      end
    end
  end

endmodule

@@ design/uoad_decide.sv @@
// Drive decision from front band and side distances, with the held command.
// Depends on uoad_pkg.
module uoad_decide (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  uoad_pkg::uoad_ranges_t ranges,
  output uoad_pkg::uoad_cmd_t    cmd_next
);
  import uoad_pkg::*;

  uoad_cmd_t held;
  logic      near20;
  logic      near10;

  function automatic uoad_cmd_t steer(logic [7:0] a, logic [7:0] b,
                                      logic [9:0] da, logic [9:0] db,
                                      logic [9:0] back);
    uoad_cmd_t c;
    priority if (a < b) begin
      c = '{direction: DIR_RIGHT, duty_a: da, duty_b: db};
    end else if (a > b) begin
      c = '{direction: DIR_LEFT, duty_a: da, duty_b: db};
    end else begin
      c = '{direction: DIR_BACK, duty_a: back, duty_b: back};
    end
    return c;
  endfunction

  always_comb begin
    near20   = (ranges.side_a < SIDE_WARN) || (ranges.side_b < SIDE_WARN);
    near10   = (ranges.side_a < SIDE_CRIT) || (ranges.side_b < SIDE_CRIT);
    cmd_next = held;
    priority if (ranges.front > BAND_FAR) begin
      if (near10) begin
        cmd_next = steer(ranges.side_a, ranges.side_b, DUTY_ZERO, DUTY_800, DUTY_360);
      end else begin
        cmd_next = '{direction: DIR_FWD, duty_a: DUTY_380, duty_b: DUTY_380};
      end
    end else if (ranges.front > BAND_MID) begin
      if (near20) begin
        cmd_next = steer(ranges.side_a, ranges.side_b, DUTY_700, DUTY_700, DUTY_340);
      end else begin
        cmd_next = '{direction: DIR_FWD, duty_a: DUTY_360, duty_b: DUTY_360};
      end
    end else if (ranges.front > BAND_NEAR) begin
      if (near20) begin
        cmd_next = steer(ranges.side_a, ranges.side_b, DUTY_700, DUTY_700, DUTY_320);
      end else begin
        cmd_next = '{direction: DIR_FWD, duty_a: DUTY_340, duty_b: DUTY_340};
      end
    end else if (ranges.front > BAND_CLOSE) begin
      if (near20) begin
        cmd_next = steer(ranges.side_a, ranges.side_b, DUTY_600, DUTY_600, DUTY_300);
      end else begin
        cmd_next = '{direction: DIR_FWD, duty_a: DUTY_320, duty_b: DUTY_320};
      end
    end else if (ranges.front > BAND_STOP) begin
      if (near20) begin
        cmd_next = steer(ranges.side_a, ranges.side_b, DUTY_600, DUTY_600, DUTY_300);
      end
    end else begin
      cmd_next = '{direction: DIR_BACK, duty_a: DUTY_450, duty_b: DUTY_450};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '{direction: DIR_STOP, duty_a: DUTY_ZERO, duty_b: DUTY_ZERO};
    end else if (fire) begin
      held <= cmd_next;
    end
  end

endmodule

@@ design/ultrasonic_obstacle_avoid_drive_core.sv @@
// Top level of the ultrasonic obstacle-avoid drive core.
// Depends on uoad_pkg, uoad_if, uoad_capture and uoad_decide.
//
// Channels: echo (sink) takes one capture transaction per edge: sensor code
// (0 front, 1 side A, 2 side B, 3 ignored) and the timer stamp of the edge.
// drive (source) returns exactly one transaction per echo transaction: the
// direction, both PWM duties and the three latest distances in centimetres.
// Path: a transaction taken from echo sits in the input register, passes
// the capture and decision logic and is then held in the output register,
// from which it is offered on drive.
// Throughput: one transaction per cycle while drive is not held off; the
// pairing, divide-by-58 multiply and band compares run combinationally
// between the registers; per-sensor state updates with the output register.
// Stall: while drive is held off, the output register keeps its transaction,
// the input register takes one more, then echo.ready drops until drive moves.
// Reset: synchronous; clears both valid flags, all edge pairs, lengths and
// distances, and sets the held command to stop with zero duties.
module ultrasonic_obstacle_avoid_drive_core #(
  parameter int TIMER_BITS = 16
) (
  input logic         clk,
  input logic         rst,
  uoad_echo_if.sink   echo,
  uoad_drive_if.source drive
);
  import uoad_pkg::*;

  logic         in_valid;
  logic [1:0]   in_sensor;
  logic [15:0]  in_stamp;
  logic         out_valid;
  uoad_cmd_t    out_cmd;
  uoad_ranges_t out_ranges;

  logic         advance;
  logic         fire;
  uoad_ranges_t ranges_next;
  uoad_cmd_t    cmd_next;

  assign advance    = !out_valid || drive.ready;
  assign fire       = in_valid && advance;
  assign echo.ready = !in_valid || advance;

  uoad_capture #(
    .TIMER_BITS(TIMER_BITS)
  ) u_capture (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .sensor     (in_sensor),
    .stamp      (in_stamp),
    .ranges_next(ranges_next)
  );

  uoad_decide u_decide (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .ranges  (ranges_next),
    .cmd_next(cmd_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (echo.ready) begin
      in_valid <= echo.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (echo.ready && echo.valid) begin
      in_sensor <= echo.sensor;
      in_stamp  <= echo.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_cmd    <= cmd_next;
      out_ranges <= ranges_next;
    end
  end

  assign drive.valid     = out_valid;
  assign drive.direction = out_cmd.direction;
  assign drive.duty_a    = out_cmd.duty_a;
  assign drive.duty_b    = out_cmd.duty_b;
  assign drive.front_cm  = out_ranges.front;
  assign drive.side_a_cm = out_ranges.side_a;
  assign drive.side_b_cm = out_ranges.side_b;

  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    drive.valid |-> drive.direction <= DIR_RIGHT)
    else $error("direction code out of range");

  a_close_backs_off: assert property (@(posedge clk) disable iff (rst)
    drive.valid && drive.front_cm <= BAND_STOP |->
      drive.direction == DIR_BACK && drive.duty_a == DUTY_450 && drive.duty_b == DUTY_450)
    else $error("close front obstacle without back-off");

  a_fwd_balanced: assert property (@(posedge clk) disable iff (rst)
    drive.valid && drive.direction == DIR_FWD |-> drive.duty_a == drive.duty_b)
    else $error("forward command with unequal duties");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !drive.valid && !in_valid)
    else $error("pipeline not empty after reset");

endmodule
